// ----- rtl/fir_circ_pkg.sv -----
package fir_circ_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_TAPS_DEF     = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 16;

  // Fixed widths of the datapath and of the request and result fields.
  localparam int ACC_WIDTH    = 40;
  localparam int NUM_TAPS_W   = 6;
  localparam int COEF_INDEX_W = 5;
  localparam int REQ_W        = 2;
  localparam int OUT_WIDTH    = 16;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RST = NUM_TAPS_W'(31);

  typedef enum logic [REQ_W-1:0] {
    REQ_FILTER = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_SAT
  } state_t;

endpackage

// ----- rtl/fir_circ_ram.sv -----
module fir_circ_ram #(
  parameter int WIDTH = fir_circ_pkg::SAMPLE_WIDTH_DEF,
  parameter int DEPTH = fir_circ_pkg::MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fir_filter_circular_top.sv -----
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -----------------------------------------
// in        sink       in_valid / in_stall  req_type, sample, coef_index, coef_value
// out       source     out_valid/out_stall  filtered, saturated
// cfg       sink       cfg_we               cfg_wdata (num_taps)
//
// A filter request runs through the tap loop and the ROUND and SAT states before its
// result sits in the output register; then the next request can be taken. One shared
// multiply-accumulate unit handles a tap per cycle behind the registered memory reads.
// Load and clear requests finish on acceptance. Reset is synchronous and active high and
// clears the history and coefficient valid bits at once, so no clearing pass is needed.
// A stalled result waits in its register; only the next finished result holds the sequencer.

module fir_filter_circular_top #(
  parameter int MAX_TAPS     = fir_circ_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = fir_circ_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = fir_circ_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fir_circ_pkg::REQ_W-1:0]        req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  logic [fir_circ_pkg::COEF_INDEX_W-1:0] coef_index,
  input  logic signed [COEF_WIDTH-1:0]          coef_value,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fir_circ_pkg::OUT_WIDTH-1:0] filtered,
  output logic                                  saturated,
  // Configuration port for num_taps.
  input  logic                                  cfg_we,
  input  logic [fir_circ_pkg::NUM_TAPS_W-1:0]   cfg_wdata
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int NW     = $clog2(MAX_TAPS + 1);
  localparam int AccW   = fir_circ_pkg::ACC_WIDTH;
  localparam int OutW   = fir_circ_pkg::OUT_WIDTH;
  localparam int ProdW  = SAMPLE_WIDTH + COEF_WIDTH;

  // Rounding adds half of the last kept bit; the limits are the signed sample range.
  localparam logic signed [AccW-1:0] RoundBit = AccW'(64'd1 << (COEF_WIDTH - 2));
  localparam logic signed [AccW-1:0] SatHi =
    $signed({{(AccW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}});
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  fir_circ_pkg::state_t state, state_next;

  logic [fir_circ_pkg::NUM_TAPS_W-1:0] num_taps;
  logic [AW-1:0]       wp;
  logic [MAX_TAPS-1:0] hist_valid;
  logic [MAX_TAPS-1:0] coef_valid;

  logic accept;
  logic issue;
  logic out_load;
  logic issuing;

  // Tap count and write position as seen by the request being accepted.
  logic [NW-1:0] n_in;
  logic [AW-1:0] wp_eff;
  logic [AW-1:0] wp_adv;
  logic          idx_ok;

  // Sequencer registers for the tap loop.
  logic [NW-1:0] n_r;
  logic [AW-1:0] tap;
  logic [AW-1:0] pos;
  logic          last_tap;

  // Pipeline behind the memories: s1 holds read data, s2 holds the product.
  logic s1_valid, s1_last, s2_valid, s2_last;
  logic hv_q, cv_q;
  logic signed [SAMPLE_WIDTH-1:0] hist_rd;
  logic signed [COEF_WIDTH-1:0]   coef_rd;
  logic signed [SAMPLE_WIDTH-1:0] op_s;
  logic signed [COEF_WIDTH-1:0]   op_c;
  logic signed [ProdW-1:0]        prod;
  logic signed [AccW-1:0]         acc;
  logic signed [AccW-1:0]         res;
  logic                           sat_hi, sat_lo;

  logic hist_we, coef_we;

  assign accept = in_valid && !in_stall;

  // A tap count of zero runs as one tap, and one above the memory depth is clamped.
  always_comb begin
    if (num_taps == '0) begin
      n_in = NW'(1);
    end else if (32'(num_taps) > MAX_TAPS) begin
      n_in = NW'(MAX_TAPS);
    end else begin
      n_in = NW'(num_taps);
    end
  end

  // A write position left stale by a smaller tap count restarts at zero.
  always_comb begin
    wp_eff = (32'(wp) >= 32'(n_in)) ? '0 : wp;
    wp_adv = (32'(wp_eff) + 1 >= 32'(n_in)) ? '0 : AW'(32'(wp_eff) + 1);
  end

  assign idx_ok = 32'(coef_index) < MAX_TAPS;

  assign hist_we = accept && (fir_circ_pkg::req_t'(req_type) == fir_circ_pkg::REQ_FILTER);
  assign coef_we = accept && (fir_circ_pkg::req_t'(req_type) == fir_circ_pkg::REQ_LOAD)
                   && idx_ok;

  assign last_tap = (NW'(tap) == n_r - NW'(1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      fir_circ_pkg::ST_IDLE: begin
        if (hist_we) begin
          state_next = fir_circ_pkg::ST_MAC;
        end
      end
      fir_circ_pkg::ST_MAC: begin
        if (s2_valid && s2_last) begin
          state_next = fir_circ_pkg::ST_ROUND;
        end
      end
      fir_circ_pkg::ST_ROUND: begin
        state_next = fir_circ_pkg::ST_SAT;
      end
      fir_circ_pkg::ST_SAT: begin
        if (out_load) begin
          state_next = fir_circ_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fir_circ_pkg::ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      fir_circ_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      fir_circ_pkg::ST_MAC: begin
        issue = issuing;
      end
      fir_circ_pkg::ST_ROUND: begin
        in_stall = 1'b1;
      end
      fir_circ_pkg::ST_SAT: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fir_circ_pkg::ST_IDLE;
      num_taps   <= fir_circ_pkg::NUM_TAPS_RST;
      wp         <= '0;
      hist_valid <= '0;
      coef_valid <= '0;
      issuing    <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_taps <= cfg_wdata;
      end
      if (accept) begin
        unique case (fir_circ_pkg::req_t'(req_type))
          fir_circ_pkg::REQ_FILTER: begin
            hist_valid[wp_eff] <= 1'b1;
            wp                 <= wp_adv;
            issuing            <= 1'b1;
          end
          fir_circ_pkg::REQ_LOAD: begin
            if (idx_ok) begin
              coef_valid[AW'(coef_index)] <= 1'b1;
            end
          end
          fir_circ_pkg::REQ_CLEAR: begin
            hist_valid <= '0;
            wp         <= '0;
          end
          default: begin
          end
        endcase
      end
      if (issue && last_tap) begin
        issuing <= 1'b0;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The loop starts at the newest sample and walks backwards, wrapping at the tap count.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      n_r <= n_in;
      tap <= '0;
      pos <= wp_eff;
    end else if (issue) begin
      tap <= tap + AW'(1);
      pos <= (pos == '0) ? AW'(n_r - NW'(1)) : pos - AW'(1);
    end
    hv_q    <= hist_valid[pos];
    cv_q    <= coef_valid[tap];
    s1_last <= issue && last_tap;
    s2_last <= s1_last;
  end

  fir_circ_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_eff),
    .wdata (sample),
    .raddr (pos),
    .rdata (hist_rd)
  );

  fir_circ_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .raddr (tap),
    .rdata (coef_rd)
  );

  // History entries never written since reset or a clear, and coefficients never written since reset, read as zero.
  assign op_s = hv_q ? hist_rd : '0;
  assign op_c = cv_q ? coef_rd : '0;

  // The shared multiply-accumulate unit; the accumulator then takes the rounding add.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prod <= op_s * op_c;
    end
    if (hist_we) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + AccW'(prod);
    end else if (state == fir_circ_pkg::ST_ROUND) begin
      acc <= acc + RoundBit;
    end
  end

  assign res    = acc >>> (COEF_WIDTH - 1);
  assign sat_hi = res > SatHi;
  assign sat_lo = res < SatLo;

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sat_hi) begin
        filtered <= OutW'(SatHi);
      end else if (sat_lo) begin
        filtered <= OutW'(SatLo);
      end else begin
        filtered <= OutW'(res);
      end
      saturated <= sat_hi || sat_lo;
    end
  end

  // Products only flow while the sequencer is in its tap loop.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> state == fir_circ_pkg::ST_MAC)
    else $error("product arrived outside the tap loop");

  // Reads are issued only during the tap loop.
  assert property (@(posedge clk) disable iff (rst)
    issuing |-> state == fir_circ_pkg::ST_MAC)
    else $error("tap reads pending outside the tap loop");

  // An accepted filter request starts the loop with reads pending.
  assert property (@(posedge clk) disable iff (rst)
    hist_we |=> (state == fir_circ_pkg::ST_MAC) && issuing)
    else $error("filter request did not start the tap loop");

  // A clipped result sits exactly on one of the two limits.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (filtered == OutW'(SatHi)) || (filtered == OutW'(SatLo)))
    else $error("saturation flag set on a value inside the range");

endmodule

// ----- tb/sv/fir_result_checker.sv -----
`timescale 1ns / 100ps

module fir_result_checker
  import fir_circ_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [REQ_W-1:0]                  req_type,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
  input  logic [COEF_INDEX_W-1:0]           coef_index,
  input  logic signed [COEF_WIDTH_DEF-1:0]  coef_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [OUT_WIDTH-1:0]       filtered,
  input  logic                              saturated,
  input  logic                              cfg_we,
  input  logic [NUM_TAPS_W-1:0]             cfg_wdata,
  output int                                mismatch_count,
  output int                                results_pending
);

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] filtered;
    logic                        saturated;
  } fir_result_t;

  // Shadow copy of the filter state.
  logic signed [SAMPLE_WIDTH_DEF-1:0] hist_mdl [MAX_TAPS_DEF];
  logic signed [COEF_WIDTH_DEF-1:0]   coef_mdl [MAX_TAPS_DEF];
  logic [COEF_INDEX_W-1:0]            wr_pos_mdl;
  logic [NUM_TAPS_W-1:0]              taps_cfg_mdl;

  fir_result_t expected_outputs[$];
  int          fail_tally = 0;

  // Writes one sample into the history and returns the filter output for it.
  function automatic fir_result_t fir_filter_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] x);
    int                 n;
    int                 pos;
    logic signed [31:0] prod;
    logic signed [ACC_WIDTH-1:0] acc;
    logic signed [ACC_WIDTH-1:0] shifted;
    fir_result_t        r;
    if (taps_cfg_mdl == 0) n = 1;
    else if (taps_cfg_mdl > MAX_TAPS_DEF) n = MAX_TAPS_DEF;
    else n = int'(taps_cfg_mdl);
    // A write position left over from a larger tap count restarts at zero.
    if (int'(wr_pos_mdl) >= n) wr_pos_mdl = '0;
    hist_mdl[wr_pos_mdl] = x;
    pos = int'(wr_pos_mdl);
    acc = '0;
    for (int i = 0; i < n; i++) begin
      prod = coef_mdl[i] * hist_mdl[pos];
      acc  = acc + prod;
      pos  = (pos == 0) ? n - 1 : pos - 1;
    end
    if (int'(wr_pos_mdl) + 1 >= n) wr_pos_mdl = '0;
    else wr_pos_mdl = wr_pos_mdl + 1'b1;
    acc     = acc + 40'sd16384;
    shifted = acc >>> (COEF_WIDTH_DEF - 1);
    if (shifted > 32767) begin
      r.filtered  = 16'sh7fff;
      r.saturated = 1'b1;
    end else if (shifted < -32768) begin
      r.filtered  = 16'sh8000;
      r.saturated = 1'b1;
    end else begin
      r.filtered  = shifted[OUT_WIDTH-1:0];
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic log_failure(input string what, input fir_result_t want, input fir_result_t got);
    fail_tally++;
    if (fail_tally <= 10)
      $display("[%0t] %s: expected filtered=%0d saturated=%0b, got filtered=%0d saturated=%0b",
               $realtime, what, want.filtered, want.saturated, got.filtered, got.saturated);
  endtask

  always @(posedge clk) begin
    fir_result_t want;
    fir_result_t got;
    if (rst) begin
      foreach (hist_mdl[k]) hist_mdl[k] = '0;
      foreach (coef_mdl[k]) coef_mdl[k] = '0;
      wr_pos_mdl   = '0;
      taps_cfg_mdl = NUM_TAPS_RST;
      expected_outputs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.filtered  = filtered;
        got.saturated = saturated;
        if (expected_outputs.size() == 0) begin
          log_failure("result with no request waiting", '0, got);
        end else begin
          want = expected_outputs.pop_front();
          if (got.filtered !== want.filtered || got.saturated !== want.saturated)
            log_failure("result mismatch", want, got);
        end
      end
      if (cfg_we) taps_cfg_mdl = cfg_wdata;
      if (in_valid && !in_stall) begin
        case (req_type)
          REQ_FILTER: expected_outputs.push_back(fir_filter_sample(sample));
          REQ_LOAD:   coef_mdl[coef_index] = coef_value;
          REQ_CLEAR: begin
            foreach (hist_mdl[k]) hist_mdl[k] = '0;
            wr_pos_mdl = '0;
          end
          default: ;
        endcase
      end
    end
    mismatch_count  <= fail_tally;
    results_pending <= expected_outputs.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fir_circ_pkg::*;

  // Hard ceiling on the run.
  localparam int CYCLE_LIMIT = 1000000;
  // Settling time after the last result; it covers a 32-tap filter request with margin.
  localparam int DRAIN_CYCLES = 48;
  // Random requests per phase; twelve phases plus the directed part come to
  // roughly 1250 requests.
  localparam int PHASE_ITEMS = 102;
  localparam int NUM_PHASES  = 12;
  // The request code the block does not define; it must be dropped silently.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [REQ_W-1:0]                  req_type;
  logic signed [SAMPLE_WIDTH_DEF-1:0] sample;
  logic [COEF_INDEX_W-1:0]           coef_index;
  logic signed [COEF_WIDTH_DEF-1:0]  coef_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [OUT_WIDTH-1:0]       filtered;
  logic                              saturated;
  logic                              cfg_we;
  logic [NUM_TAPS_W-1:0]             cfg_wdata;

  int mismatch_count;
  int results_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;

  fir_filter_circular_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .filtered   (filtered),
    .saturated  (saturated),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // The checker watches both channels and the configuration port on its own;
  // this module only produces stimulus and reads back the failure count.
  fir_result_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .sample          (sample),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered        (filtered),
    .saturated       (saturated),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: if the run has not ended by the limit, something is hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL fir_filter_circular_top");
    $finish;
  end

  // Result side. Normally it stalls at random with the current percentage.
  // When the stimulus asks for a hold-off, it stalls solidly until the hold-off
  // runs out, so that the block backs up and stalls its request input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offers one request and returns in the time step of the edge that took it.
  // Valid stays high afterwards, so back-to-back requests see no bubble unless
  // the random idle draw inserts one; valid is only ever assigned once per step.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic signed [SAMPLE_WIDTH_DEF-1:0] smp,
                              input logic [COEF_INDEX_W-1:0] idx,
                              input logic signed [COEF_WIDTH_DEF-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    sample     <= smp;
    coef_index <= idx;
    coef_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Picks a random request. Filter requests dominate since they exercise the
  // datapath; loads keep the coefficient table moving, and a few clears and
  // undefined codes are mixed in.
  task automatic send_random_request();
    int                                pick;
    logic [REQ_W-1:0]                  kind;
    logic signed [SAMPLE_WIDTH_DEF-1:0] smp;
    logic signed [COEF_WIDTH_DEF-1:0]  val;
    pick = $urandom_range(0, 99);
    if (pick < 72) kind = REQ_FILTER;
    else if (pick < 92) kind = REQ_LOAD;
    else if (pick < 96) kind = REQ_CLEAR;
    else kind = REQ_UNKNOWN;
    // Full-scale samples turn up now and then so the saturation paths get hit.
    pick = $urandom_range(0, 19);
    if (pick == 0) smp = 16'sh7fff;
    else if (pick == 1) smp = 16'sh8000;
    else smp = 16'($urandom);
    // Mostly modest coefficients, so that many outputs stay in range and the
    // rounding is visible; the rest span the full Q1.15 range.
    if ($urandom_range(0, 3) == 0) val = 16'($urandom);
    else val = 16'(int'($urandom_range(0, 2047)) - 1024);
    send_request(kind, smp, 5'($urandom), val);
  endtask

  // Brings the block to rest: stop offering, wait for every outstanding
  // result, then give any load or clear still in flight time to finish.
  // The first edge lets the checker's pending count catch up with the last
  // accepted request before it is looked at.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_num_taps(input logic [NUM_TAPS_W-1:0] taps);
    cfg_we    <= 1'b1;
    cfg_wdata <= taps;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [NUM_TAPS_W-1:0] tap_plan [NUM_PHASES];
    // Every input starts at a known value before the first edge.
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = REQ_FILTER;
    sample        = '0;
    coef_index    = '0;
    coef_value    = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_left     = 0;
    send_idle_pct = 18;
    recv_idle_pct = 49;
    // Tap counts per phase: both ends of the legal range, zero (treated as
    // one), the all-ones code (treated as the maximum), and a few in between.
    // Going from a large count to a small one leaves a stale write position.
    tap_plan = '{6'd32, 6'd1, 6'd17, 6'd0, 6'd63, 6'd5, 6'd32, 6'd3, 6'd24, 6'd2,
                 6'd32, 6'd0};
    tap_plan[NUM_PHASES-1] = 6'($urandom_range(0, 63));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset tap count of 31.
    // With an all-zero coefficient table the output must be zero.
    send_request(REQ_FILTER, 16'sh7fff, 5'd0, 16'sd0);
    // Extreme coefficients, including the top table entry.
    send_request(REQ_LOAD, 16'sd0, 5'd0, 16'sh7fff);
    send_request(REQ_LOAD, 16'sd0, 5'd1, 16'sh8000);
    send_request(REQ_LOAD, 16'sd0, 5'd31, 16'sd1);
    send_request(REQ_FILTER, 16'sh7fff, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sh8000, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sd0, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sd1, 5'd0, 16'sd0);
    send_request(REQ_FILTER, -16'sd1, 5'd0, 16'sd0);
    // The undefined request code must leave no trace.
    send_request(REQ_UNKNOWN, 16'sh7fff, 5'd7, 16'sh7fff);
    // A clear empties the history and rewinds the write position but keeps
    // the coefficients.
    send_request(REQ_CLEAR, 16'sh1234, 5'd3, 16'sh1234);
    send_request(REQ_FILTER, 16'sh8000, 5'd0, 16'sd0);
    // Two full negative coefficients on two full negative samples overflow
    // upward and must clip high.
    send_request(REQ_LOAD, 16'sd0, 5'd0, 16'sh8000);
    send_request(REQ_LOAD, 16'sd0, 5'd1, 16'sh8000);
    send_request(REQ_FILTER, 16'sh8000, 5'd0, 16'sd0);
    // Two full positive samples then drive the sum past the low limit.
    send_request(REQ_FILTER, 16'sh7fff, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sh7fff, 5'd0, 16'sd0);
    // A half-scale single tap puts the sum exactly on the rounding boundary.
    send_request(REQ_LOAD, 16'sd0, 5'd0, 16'sh4000);
    send_request(REQ_LOAD, 16'sd0, 5'd1, 16'sd0);
    send_request(REQ_LOAD, 16'sd0, 5'd31, 16'sd0);
    send_request(REQ_CLEAR, 16'sd0, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sd1, 5'd0, 16'sd0);
    send_request(REQ_FILTER, -16'sd1, 5'd0, 16'sd0);
    send_request(REQ_FILTER, 16'sd3, 5'd0, 16'sd0);

    // Random phases. The first third has a busy sender and a sluggish
    // receiver, the middle third the reverse, the last third no idling at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      write_num_taps(tap_plan[p]);
      if (p < NUM_PHASES / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 49;
      end else if (p < 2 * NUM_PHASES / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // In the first phase the receiver holds off for a long stretch while
      // requests keep coming, so the block fills up and stalls its input.
      if (p == 0) hold_left = 600;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end

    // Drain everything, then give the verdict.
    settle_block();
    if (mismatch_count == 0) begin
      $display("PASS fir_filter_circular_top");
    end else begin
      $display("FAIL fir_filter_circular_top");
    end
    $finish;
  end

endmodule
